// ===== rtl/partial_distance_prune_core_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the partial distance prune core
// Shared property shapes, clocked on clock; the first two are disabled by reset.
// ---------------------------------------------------------------------------
`ifndef PARTIAL_DISTANCE_PRUNE_CORE_DEFINES_SVH
`define PARTIAL_DISTANCE_PRUNE_CORE_DEFINES_SVH

// same-cycle implication, quiet during reset
`define PDP_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, quiet during reset
`define PDP_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication that also watches reset itself
`define PDP_ASSERT_NXT_ALWAYS(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/pdp_pkg.sv =====
// ---------------------------------------------------------------------------
// pdp_pkg
// Widths and shared types of the partial distance prune core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package pdp_pkg;

   localparam int CompWidth   = 16;
   localparam int SumWidth    = 48;
   localparam int CountWidth  = 32;
   localparam int DiffWidth   = CompWidth + 1;
   localparam int SqWidth     = 2 * DiffWidth;

   localparam int ReqDataWidth = 2 * CompWidth + 2 * SumWidth;
   localparam int RspDataWidth = SumWidth + CountWidth;

   localparam logic [SumWidth-1:0]   SumMax   = {SumWidth{1'b1}};
   localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};

   // side fields that travel alongside the component pair
   typedef struct packed {
      logic [SumWidth-1:0] prior_sum;
      logic                prior_pruned;
      logic [SumWidth-1:0] limit;
      logic                last_element;
      logic                last_of_batch;
   } pdp_side_type;

endpackage

// ===== rtl/partial_distance_prune_core.sv =====
// ---------------------------------------------------------------------------
// partial_distance_prune_core
// Squared Euclidean distance with early termination over a dimension slice.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

// Channel   Dir  Word contents
// req_*     in   one query/base component pair with upstream total and limit
// rsp_*     out  one candidate verdict, emitted on its final component
//
// A word passes the stage one, stage two and result registers from req
// accept to rsp valid; one word is taken every cycle unless the pipe is
// held. Stage one registers the word, stage two squares the component
// difference, stage three accumulates, checks the limit and loads the result
// register. Only a final-component word waiting at stage three behind a
// stalled rsp holds the pipe; other words retire without a slot. Synchronous
// reset empties the pipe and clears total, candidate and survivor state.

module partial_distance_prune_core (
   input  logic                               clock,
   input  logic                               reset,
   // req_tdata, lowest bit up: query_value[15:0], base_value[15:0],
   //                           prior_sum[47:0], limit[47:0]
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [pdp_pkg::ReqDataWidth-1:0]   req_tdata,
   // req_tuser, lowest bit up: prior_pruned, last_of_batch
   input  logic [1:0]                         req_tuser,
   input  logic                               req_tlast,
   // rsp_tdata, lowest bit up: distance_total[47:0], survivor_count[31:0]
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [pdp_pkg::RspDataWidth-1:0]   rsp_tdata,
   // rsp_tuser: pruned
   output logic [0:0]                         rsp_tuser,
   output logic                               rsp_tlast
);
   import pdp_pkg::*;

   // stage one: input register
   logic                        s1_valid_ff, s1_valid_in;
   logic signed [CompWidth-1:0] s1_query_ff, s1_base_ff;
   pdp_side_type                s1_side_ff;

   // stage two: squared difference plus side fields
   logic                        s2_valid_ff, s2_valid_in;
   logic [SqWidth-1:0]          s2_square_ff;
   pdp_side_type                s2_side_ff;

   // candidate state
   logic [SumWidth-1:0]         acc_ff, acc_in;
   logic                        mid_ff, mid_in;
   logic                        skip_ff, skip_in;
   logic [CountWidth-1:0]       surv_ff, surv_in;

   // result register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [SumWidth-1:0]         rsp_total_ff;
   logic [CountWidth-1:0]       rsp_count_ff;
   logic                        rsp_pruned_ff, rsp_batch_ff;

   logic                        out_free, s2_go, s2_ready, s1_go;
   logic [SumWidth-1:0]         base_sum, new_acc;
   logic                        cand_skip, cand_pruned, batch_close;
   logic [SumWidth:0]           wide_sum;
   logic [CountWidth-1:0]       count_now;

   // handshake chain: a non-final word at stage two never waits
   always_comb begin
      out_free    = !rsp_valid_ff || rsp_tready;
      s2_go       = s2_valid_ff && (!s2_side_ff.last_element || out_free);
      s2_ready    = !s2_valid_ff || s2_go;
      s1_go       = s1_valid_ff && s2_ready;
      req_tready  = !s1_valid_ff || s1_go;
      s1_valid_in = (req_tvalid && req_tready) || (s1_valid_ff && !s1_go);
      s2_valid_in = s1_go || (s2_valid_ff && !s2_go);
   end

   // stage one load
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_query_ff                <= req_tdata[CompWidth-1:0];
         s1_base_ff                 <= req_tdata[2*CompWidth-1:CompWidth];
         s1_side_ff.prior_sum       <= req_tdata[2*CompWidth+SumWidth-1:2*CompWidth];
         s1_side_ff.limit           <= req_tdata[ReqDataWidth-1:2*CompWidth+SumWidth];
         s1_side_ff.prior_pruned    <= req_tuser[0];
         s1_side_ff.last_of_batch   <= req_tuser[1];
         s1_side_ff.last_element    <= req_tlast;
      end
   end

   pdp_sqdiff u_sqdiff (
      .clock       (clock),
      .enable      (s1_go),
      .query_value (s1_query_ff),
      .base_value  (s1_base_ff),
      .square_ff   (s2_square_ff)
   );

   always_ff @(posedge clock) begin
      if (s1_go) begin
         s2_side_ff <= s1_side_ff;
      end
   end

   // stage three: accumulate with saturation, then check the limit
   always_comb begin
      base_sum    = mid_ff ? acc_ff  : s2_side_ff.prior_sum;
      cand_skip   = mid_ff ? skip_ff : s2_side_ff.prior_pruned;
      wide_sum    = {1'b0, base_sum} + (SumWidth + 1)'(s2_square_ff);
      if (cand_skip) begin
         new_acc = base_sum;
      end else if (wide_sum[SumWidth]) begin
         new_acc = SumMax;
      end else begin
         new_acc = wide_sum[SumWidth-1:0];
      end
      cand_pruned = cand_skip || (new_acc > s2_side_ff.limit);
      batch_close = s2_side_ff.last_element && s2_side_ff.last_of_batch;
      count_now   = (!cand_pruned && surv_ff != CountMax) ? surv_ff + 1'b1 : surv_ff;

      acc_in  = acc_ff;
      mid_in  = mid_ff;
      skip_in = skip_ff;
      surv_in = surv_ff;
      if (s2_go) begin
         acc_in = new_acc;
         if (s2_side_ff.last_element) begin
            mid_in  = 1'b0;
            skip_in = 1'b0;
            surv_in = batch_close ? '0 : count_now;
         end else begin
            mid_in  = 1'b1;
            skip_in = cand_skip;
         end
      end

      if (s2_go && s2_side_ff.last_element) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         acc_ff       <= '0;
         mid_ff       <= 1'b0;
         skip_ff      <= 1'b0;
         surv_ff      <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         acc_ff       <= acc_in;
         mid_ff       <= mid_in;
         skip_ff      <= skip_in;
         surv_ff      <= surv_in;
      end
   end

   // result payload: load only on a closing word, hold while stalled
   always_ff @(posedge clock) begin
      if (s2_go && s2_side_ff.last_element) begin
         rsp_total_ff  <= cand_pruned ? '0 : new_acc;
         rsp_pruned_ff <= cand_pruned;
         rsp_count_ff  <= count_now;
         rsp_batch_ff  <= batch_close;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = {rsp_count_ff, rsp_total_ff};
   assign rsp_tuser[0] = rsp_pruned_ff;
   assign rsp_tlast    = rsp_batch_ff;

endmodule

// ===== rtl/pdp_sqdiff.sv =====
// ---------------------------------------------------------------------------
// pdp_sqdiff
// Registered squared difference of one query/base component pair.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pdp_sqdiff (
   input  logic                                 clock,
   input  logic                                 enable,
   input  logic signed [pdp_pkg::CompWidth-1:0] query_value,
   input  logic signed [pdp_pkg::CompWidth-1:0] base_value,
   output logic        [pdp_pkg::SqWidth-1:0]   square_ff
);
   import pdp_pkg::*;

   logic signed [DiffWidth-1:0] diff;
   logic        [DiffWidth-1:0] mag;
   logic        [SqWidth-1:0]   square_in;

   always_comb begin
      diff      = DiffWidth'(query_value) - DiffWidth'(base_value);
      mag       = diff[DiffWidth-1] ? DiffWidth'(-diff) : DiffWidth'(diff);
      square_in = SqWidth'(mag) * SqWidth'(mag);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         square_ff <= square_in;
      end
   end

endmodule

// ===== rtl/pdp_checker.sv =====
// ---------------------------------------------------------------------------
// pdp_checker
// Port-level checks on the partial distance prune core, bound to the top.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "partial_distance_prune_core_defines.svh"

module pdp_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [pdp_pkg::RspDataWidth-1:0] rsp_tdata,
   input logic [0:0]                       rsp_tuser,
   input logic                             rsp_tlast
);
   import pdp_pkg::*;

   // a stalled result holds its word
   `PDP_ASSERT_NXT(a_rsp_hold, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast),
      "rsp word changed while stalled")

   // a pruned verdict carries no distance
   `PDP_ASSERT_IMP(a_pruned_zero, rsp_tvalid && rsp_tuser[0],
      rsp_tdata[SumWidth-1:0] == '0, "pruned result with non-zero distance")

   // a survivor is counted in its own result
   `PDP_ASSERT_IMP(a_survivor_counted, rsp_tvalid && !rsp_tuser[0],
      rsp_tdata[RspDataWidth-1:SumWidth] != '0, "survivor result with zero count")

   // reset empties the result register
   `PDP_ASSERT_NXT_ALWAYS(a_reset_empty, reset, !rsp_tvalid, "rsp valid straight after reset")

endmodule

bind partial_distance_prune_core pdp_checker u_pdp_checker (.*);

// ===== bench/tb_partial_distance_prune_core.sv =====
// ---------------------------------------------------------------------------
// tb_partial_distance_prune_core
// Streams component words through the prune core and checks every verdict
// against a cycle-free prediction of the distance, prune flag and survivor
// count. Runs directed corner cases, random candidates and a long back-pressure
// stretch.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_partial_distance_prune_core;
   import pdp_pkg::*;

   // one component word as the upstream stage offers it
   typedef struct {
      logic signed [CompWidth-1:0] query_value;
      logic signed [CompWidth-1:0] base_value;
      logic [SumWidth-1:0]         prior_sum;
      logic                        prior_pruned;
      logic [SumWidth-1:0]         limit;
      logic                        last_element;
      logic                        last_of_batch;
   } component_word_type;

   // one candidate verdict as the core should emit it
   typedef struct {
      logic [SumWidth-1:0]   distance_total;
      logic                  pruned;
      logic [CountWidth-1:0] survivor_count;
      logic                  batch_done;
   } verdict_type;

   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [ReqDataWidth-1:0] req_tdata;   // query, base, prior_sum, limit
   logic [1:0]              req_tuser;   // prior_pruned, last_of_batch
   logic                    req_tlast;
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [RspDataWidth-1:0] rsp_tdata;   // distance_total, survivor_count
   logic [0:0]              rsp_tuser;   // pruned
   logic                    rsp_tlast;

   // predicted state of the core
   logic [SumWidth-1:0]   running_total  = '0;
   logic                  in_candidate   = 1'b0;
   logic                  skipping       = 1'b0;
   logic [CountWidth-1:0] batch_survivors = '0;

   verdict_type verdict_queue[$];
   int       mismatch_count   = 0;
   int       sent_words       = 0;
   bit       tx_gaps          = 1'b0;
   bit       rx_gaps          = 1'b0;
   int       hold_off_request = 0;

   partial_distance_prune_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Give up after a generous fixed time; a healthy run ends far earlier.
   initial begin
      #2_000_000;
      $display("Mismatches found");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Prediction
   // -------------------------------------------------------------------------

   // Advance the predicted state by one accepted word; queue a verdict when
   // the word closes its candidate.
   function automatic void predict_verdict(input component_word_type w);
      logic [CompWidth:0] diff;
      logic [CompWidth:0] mag;
      logic [SumWidth:0]  sum;
      verdict_type        v;
      // first word of a candidate: load the upstream total and prune flag
      if (!in_candidate) begin
         running_total = w.prior_sum;
         skipping      = w.prior_pruned;
      end
      // candidates pruned upstream ignore their components entirely
      if (!skipping) begin
         diff = {w.query_value[CompWidth-1], w.query_value}
              - {w.base_value[CompWidth-1], w.base_value};
         mag  = diff[CompWidth] ? -diff : diff;
         sum  = {1'b0, running_total} + (SumWidth + 1)'(mag) * (SumWidth + 1)'(mag);
         running_total = (sum > SumMax) ? SumMax : sum[SumWidth-1:0];
      end
      if (!w.last_element) begin
         in_candidate = 1'b1;
         return;
      end
      // final word: judge against the limit, which only counts here
      v.pruned         = skipping || (running_total > w.limit);
      v.distance_total = v.pruned ? '0 : running_total;
      if (!v.pruned && batch_survivors != CountMax)
         batch_survivors = batch_survivors + 1'b1;
      v.survivor_count = batch_survivors;
      v.batch_done     = w.last_of_batch;
      if (w.last_of_batch)
         batch_survivors = '0;
      in_candidate = 1'b0;
      skipping     = 1'b0;
      verdict_queue.insert(verdict_queue.size(), v);
   endfunction

   // -------------------------------------------------------------------------
   // Sender
   // -------------------------------------------------------------------------

   function automatic component_word_type make_word(
      input logic signed [CompWidth-1:0] q,
      input logic signed [CompWidth-1:0] b,
      input logic [SumWidth-1:0]         ps,
      input logic                        pp,
      input logic [SumWidth-1:0]         lim,
      input logic                        last,
      input logic                        lob
   );
      component_word_type w;
      w.query_value   = q;
      w.base_value    = b;
      w.prior_sum     = ps;
      w.prior_pruned  = pp;
      w.limit         = lim;
      w.last_element  = last;
      w.last_of_batch = lob;
      return w;
   endfunction

   // Offer one word, maybe after a one-cycle random gap, and hold it until
   // the core takes it; predict on the accepting edge.
   task automatic send_word(input component_word_type w);
      if (tx_gaps && $urandom_range(99) < 7) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {w.limit, w.prior_sum, w.base_value, w.query_value};
      req_tuser  <= {w.last_of_batch, w.prior_pruned};
      req_tlast  <= w.last_element;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_verdict(w);
      sent_words++;
   endtask

   // -------------------------------------------------------------------------
   // Receiver and checker
   // -------------------------------------------------------------------------

   // Drive rsp_tready: random stalls when enabled, and a long hold-off when
   // a test asks for one, counted down here.
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request > 0) begin
            hold_left        = hold_off_request;
            hold_off_request = 0;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= !(rx_gaps && $urandom_range(99) < 7);
         end
      end
   end

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   // Compare every accepted verdict with the oldest one predicted.
   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (verdict_queue.size() == 0) begin
            $display("%0t: verdict with none expected, expected nothing actual %0h/%b/%0d/%b",
                     $time, rsp_tdata[SumWidth-1:0], rsp_tuser[0],
                     rsp_tdata[RspDataWidth-1:SumWidth], rsp_tlast);
            mismatch_count++;
         end else begin
            want = verdict_queue.pop_front();
            check_field("distance_total", want.distance_total, rsp_tdata[SumWidth-1:0]);
            check_field("pruned", want.pruned, rsp_tuser[0]);
            check_field("survivor_count", want.survivor_count,
                        rsp_tdata[RspDataWidth-1:SumWidth]);
            check_field("batch_done", want.batch_done, rsp_tlast);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Random field sources
   // -------------------------------------------------------------------------

   function automatic logic signed [CompWidth-1:0] random_component();
      case ($urandom_range(9))
         0:       return {1'b1, {(CompWidth-1){1'b0}}};
         1:       return {1'b0, {(CompWidth-1){1'b1}}};
         2:       return '0;
         3:       return '1;
         4:       return CompWidth'($urandom_range(63)) - CompWidth'(32);
         default: return CompWidth'($urandom);
      endcase
   endfunction

   function automatic logic [SumWidth-1:0] random_sum();
      case ($urandom_range(3))
         0:       return SumWidth'({$urandom, $urandom});
         1:       return SumWidth'($urandom_range(1 << 20));
         2:       return SumMax - SumWidth'($urandom_range(1 << 24));
         default: return SumWidth'($urandom);
      endcase
   endfunction

   // Pick limits around the running total so both verdicts turn up often.
   function automatic logic [SumWidth-1:0] random_limit();
      case ($urandom_range(4))
         0:       return SumWidth'({$urandom, $urandom});
         1:       return running_total + SumWidth'($urandom);
         2:       return running_total + SumWidth'($urandom_range(1 << 31));
         3:       return running_total - SumWidth'($urandom_range(1 << 20));
         default: return SumMax;
      endcase
   endfunction

   // One candidate of random length; noise on the side fields of inner words.
   task automatic send_random_candidate(input bit close_batch);
      int                 len;
      component_word_type w;
      len = ($urandom_range(99) < 85) ? $urandom_range(1, 6) : $urandom_range(7, 16);
      for (int i = 0; i < len; i++) begin
         w.query_value   = random_component();
         w.base_value    = random_component();
         w.prior_sum     = random_sum();
         w.prior_pruned  = ($urandom_range(99) < 15);
         w.last_element  = (i == len - 1);
         w.last_of_batch = w.last_element ? close_batch : 1'($urandom_range(1));
         w.limit         = random_limit();
         send_word(w);
      end
   endtask

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // Largest differences, zero difference, and limits on either side of the
   // total.
   task automatic test_extremes();
      send_word(make_word(16'sh7fff, 16'sh8000, '0, 1'b0, SumMax, 1'b1, 1'b0));
      send_word(make_word(16'sh8000, 16'sh7fff, '0, 1'b0, SumMax, 1'b1, 1'b0));
      send_word(make_word(16'sh8000, 16'sh8000, '0, 1'b0, '0, 1'b1, 1'b0));
      send_word(make_word(16'sh0001, 16'sh0000, '0, 1'b0, '0, 1'b1, 1'b0));
      send_word(make_word(16'sh0000, 16'sh0000, SumMax, 1'b0, SumMax, 1'b1, 1'b0));
      // total equal to limit survives, one above it is pruned
      send_word(make_word(16'sh0003, 16'sh0000, 48'd7, 1'b0, 48'd16, 1'b1, 1'b0));
      send_word(make_word(16'sh0003, 16'sh0000, 48'd7, 1'b0, 48'd15, 1'b1, 1'b0));
   endtask

   // Accumulator clamps at its maximum and stays there.
   task automatic test_saturation();
      send_word(make_word(16'sd100, -16'sd100, SumMax - 48'd5, 1'b0, '0, 1'b0, 1'b0));
      send_word(make_word(16'sh7fff, 16'sh8000, '0, 1'b0, SumMax - 1'b1, 1'b1, 1'b0));
      send_word(make_word(16'sd100, -16'sd100, SumMax - 48'd40000, 1'b0, SumMax,
                          1'b1, 1'b0));
   endtask

   // Candidates pruned upstream pass through untouched.
   task automatic test_prior_pruned();
      send_word(make_word(16'sh7fff, 16'sh8000, '0, 1'b1, SumMax, 1'b0, 1'b0));
      send_word(make_word(16'sh1234, 16'sh0000, SumMax, 1'b0, SumMax, 1'b0, 1'b0));
      send_word(make_word(16'sh0000, 16'sh0001, '0, 1'b0, SumMax, 1'b1, 1'b0));
      send_word(make_word(16'sh0000, 16'sh0000, '0, 1'b1, SumMax, 1'b1, 1'b0));
   endtask

   // Batch mark on an inner word is dropped; on a final word it closes the
   // batch and clears the count.
   task automatic test_batch_marks();
      send_word(make_word(16'sh0001, 16'sh0000, '0, 1'b0, SumMax, 1'b0, 1'b1));
      send_word(make_word(16'sh0001, 16'sh0000, '0, 1'b0, SumMax, 1'b1, 1'b0));
      send_word(make_word(16'sh0002, 16'sh0000, '0, 1'b0, SumMax, 1'b1, 1'b1));
      send_word(make_word(16'sh0002, 16'sh0000, '0, 1'b0, SumMax, 1'b1, 1'b0));
   endtask

   // Random candidates: a first stretch with no gaps, then gaps on both sides.
   task automatic test_random(input int word_target);
      tx_gaps = 1'b0;
      rx_gaps = 1'b0;
      while (sent_words < word_target) begin
         if (sent_words > word_target / 4) begin
            tx_gaps = 1'b1;
            rx_gaps = 1'b1;
         end
         send_random_candidate($urandom_range(99) < 20);
      end
   endtask

   // Hold the receiver off while candidates keep coming, so the pipe fills
   // and req_tready drops.
   task automatic test_backpressure();
      tx_gaps          = 1'b0;
      hold_off_request = 300;
      repeat (20) send_random_candidate(1'($urandom_range(99) < 10));
      tx_gaps = 1'b1;
   endtask

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      req_tlast  <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      tx_gaps = 1'b1;
      rx_gaps = 1'b1;
      test_extremes();
      test_saturation();
      test_prior_pruned();
      test_batch_marks();
      test_random(760);
      test_backpressure();

      req_tvalid <= 1'b0;
      while (verdict_queue.size() != 0) @(posedge clock);
      // drain: let any stray verdict surface before judging
      repeat (10) @(posedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

// ===== partial_distance_prune_core.f =====
+incdir+rtl
rtl/pdp_pkg.sv
rtl/pdp_sqdiff.sv
rtl/partial_distance_prune_core.sv
rtl/pdp_checker.sv
bench/tb_partial_distance_prune_core.sv
